>>> rtl/ffca_pkg.sv
// Package for the first-fit chunk allocator.
// Holds sizing constants, command, status and state codes, payload and table entry types.
// No dependencies.
package ffca_pkg;

  localparam int MAX_CHUNKS   = 64;
  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 32;
  localparam int ALIGN_BYTES  = 8;

  localparam int IDX_W  = $clog2(MAX_CHUNKS);
  localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
  localparam int HEAP_W = $clog2(HEAP_BYTES + 1);
  localparam int AW     = HEAP_W + 2;
  localparam int CAP_W  = 17;

  typedef enum logic [2:0] {
    CMD_ALLOC  = 3'd0,
    CMD_ZALLOC = 3'd1,
    CMD_FREE   = 3'd2,
    CMD_RESIZE = 3'd3,
    CMD_RESET  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NULL    = 2'd1,
    ST_OVF     = 2'd2,
    ST_NOSPACE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SCAN,
    S_DECIDE,
    S_WR_OLD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] size;
    logic [15:0] count;
    logic [15:0] addr;
  } in_t;

  typedef struct packed {
    logic [15:0] result_addr;
    logic [1:0]  status;
    logic [15:0] copy_from;
    logic [15:0] copy_length;
    logic [15:0] zero_length;
  } out_t;

  typedef struct packed {
    logic [15:0]      start;
    logic [CAP_W-1:0] cap;
    logic [15:0]      used;
    logic             is_free;
  } entry_t;

endpackage

>>> rtl/ffca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/first_fit_chunk_allocator.sv
// Top level of the first-fit chunk allocator.
// Depends on ffca_pkg and ffca_ram.
//
// One command is handled at a time. The chunk table sits in one RAM and every
// table search walks it one entry per cycle through the single read port, so a
// command takes longer the more chunks the table holds; a resize that moves walks
// the table twice. Zeroed allocate first passes through a multiply state, and
// reset or null requests skip the table search. A finished result waits in the
// output register while the next transaction is accepted.
module first_fit_chunk_allocator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ffca_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ffca_pkg::out_t out_data
);

  localparam int EW = $bits(ffca_pkg::entry_t);

  ffca_pkg::state_t state_r, state_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [15:0] size_r, size_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [ffca_pkg::CNT_W-1:0]  total_r, total_nxt;
  logic [ffca_pkg::HEAP_W-1:0] heap_end_r, heap_end_nxt;
  logic [ffca_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [ffca_pkg::IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic                        hit_r, hit_nxt;
  logic [ffca_pkg::IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  ffca_pkg::entry_t            hit_ent_r, hit_ent_nxt;
  logic [ffca_pkg::IDX_W-1:0]  old_idx_r, old_idx_nxt;
  ffca_pkg::entry_t            old_ent_r, old_ent_nxt;
  logic                        find_r, find_nxt;
  logic                        move_r, move_nxt;
  ffca_pkg::out_t              res_r, res_nxt;
  ffca_pkg::out_t              out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic                       ram_we;
  logic [ffca_pkg::IDX_W-1:0] ram_waddr;
  ffca_pkg::entry_t           ram_wdata;
  logic [ffca_pkg::IDX_W-1:0] ram_raddr;
  logic [EW-1:0]              ram_rdata_raw;
  ffca_pkg::entry_t           ram_rdata;

  logic [31:0]                prod;
  logic                       match;
  logic [ffca_pkg::CAP_W-1:0] cap_new;
  logic [ffca_pkg::AW-1:0]    data_w;
  logic [ffca_pkg::AW-1:0]    end_w;
  logic                       fits;
  logic                       out_free;
  logic                       accept;

  assign ram_rdata = ffca_pkg::entry_t'(ram_rdata_raw);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign prod      = {16'd0, count_r} * {16'd0, size_r};

  always_comb begin
    if (find_r) begin
      match = chk_vld_r && (ram_rdata.start == addr_r);
    end else begin
      match = chk_vld_r && ram_rdata.is_free && (ram_rdata.cap >= {1'b0, size_r});
    end
    cap_new = ({1'b0, size_r} + ffca_pkg::CAP_W'(ffca_pkg::ALIGN_BYTES - 1))
              & ~ffca_pkg::CAP_W'(ffca_pkg::ALIGN_BYTES - 1);
    data_w  = ffca_pkg::AW'(heap_end_r) + ffca_pkg::AW'(ffca_pkg::HEADER_BYTES);
    end_w   = data_w + ffca_pkg::AW'(cap_new);
    fits    = (total_r < ffca_pkg::CNT_W'(ffca_pkg::MAX_CHUNKS))
              && (end_w <= ffca_pkg::AW'(ffca_pkg::HEAP_BYTES))
              && (data_w <= ffca_pkg::AW'(17'h0FFFF));
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    size_nxt      = size_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    total_nxt     = total_r;
    heap_end_nxt  = heap_end_r;
    idx_nxt       = idx_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_ent_nxt   = hit_ent_r;
    old_idx_nxt   = old_idx_r;
    old_ent_nxt   = old_ent_r;
    find_nxt      = find_r;
    move_nxt      = move_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ffca_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_data.cmd;
          size_nxt    = in_data.size;
          count_nxt   = in_data.count;
          addr_nxt    = in_data.addr;
          res_nxt     = '0;
          idx_nxt     = '0;
          chk_vld_nxt = 1'b0;
          move_nxt    = 1'b0;
          find_nxt    = 1'b0;
          state_nxt   = ffca_pkg::S_DONE;
          case (in_data.cmd)
            ffca_pkg::CMD_ALLOC: begin
              if (in_data.size == 16'd0) begin
                res_nxt.status = ffca_pkg::ST_NULL;
              end else begin
                state_nxt = ffca_pkg::S_SCAN;
              end
            end
            ffca_pkg::CMD_ZALLOC: begin
              state_nxt = ffca_pkg::S_MUL;
            end
            ffca_pkg::CMD_FREE: begin
              if (in_data.addr != 16'd0) begin
                find_nxt  = 1'b1;
                state_nxt = ffca_pkg::S_SCAN;
              end
            end
            ffca_pkg::CMD_RESIZE: begin
              if (in_data.addr != 16'd0) begin
                find_nxt  = 1'b1;
                state_nxt = ffca_pkg::S_SCAN;
              end else if (in_data.size == 16'd0) begin
                res_nxt.status = ffca_pkg::ST_NULL;
              end else begin
                state_nxt = ffca_pkg::S_SCAN;
              end
            end
            ffca_pkg::CMD_RESET: begin
              total_nxt    = '0;
              heap_end_nxt = ffca_pkg::HEAP_W'(ffca_pkg::HEADER_BYTES);
            end
            default: begin
            end
          endcase
        end
      end
      ffca_pkg::S_MUL: begin
        if (prod[31:16] != 16'd0) begin
          res_nxt.status = ffca_pkg::ST_OVF;
          state_nxt      = ffca_pkg::S_DONE;
        end else if (prod[15:0] == 16'd0) begin
          res_nxt.status = ffca_pkg::ST_NULL;
          state_nxt      = ffca_pkg::S_DONE;
        end else begin
          size_nxt  = prod[15:0];
          state_nxt = ffca_pkg::S_SCAN;
        end
      end
      ffca_pkg::S_SCAN: begin
        if (match) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = chk_idx_r;
          hit_ent_nxt = ram_rdata;
          state_nxt   = ffca_pkg::S_DECIDE;
        end else if (idx_r < total_r) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = idx_r[ffca_pkg::IDX_W-1:0];
          idx_nxt     = idx_r + 1'b1;
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = ffca_pkg::S_DECIDE;
        end
      end
      ffca_pkg::S_DECIDE: begin
        state_nxt = ffca_pkg::S_DONE;
        if (find_r) begin
          if (cmd_r == ffca_pkg::CMD_RESIZE) begin
            if (!hit_r || size_r == 16'd0) begin
              res_nxt.status = ffca_pkg::ST_NULL;
            end else if (hit_ent_r.cap >= {1'b0, size_r}) begin
              res_nxt.result_addr = addr_r;
            end else begin
              move_nxt    = 1'b1;
              old_idx_nxt = hit_idx_r;
              old_ent_nxt = hit_ent_r;
              find_nxt    = 1'b0;
              idx_nxt     = '0;
              chk_vld_nxt = 1'b0;
              state_nxt   = ffca_pkg::S_SCAN;
            end
          end
        end else if (hit_r || fits) begin
          if (hit_r) begin
            res_nxt.result_addr = hit_ent_r.start;
          end else begin
            res_nxt.result_addr = data_w[15:0];
            total_nxt           = total_r + 1'b1;
            heap_end_nxt        = end_w[ffca_pkg::HEAP_W-1:0];
          end
          if (cmd_r == ffca_pkg::CMD_ZALLOC) begin
            res_nxt.zero_length = size_r;
          end
          if (move_r) begin
            res_nxt.copy_from   = addr_r;
            res_nxt.copy_length = old_ent_r.used;
            state_nxt           = ffca_pkg::S_WR_OLD;
          end
        end else begin
          res_nxt.status = ffca_pkg::ST_NOSPACE;
        end
      end
      ffca_pkg::S_WR_OLD: begin
        state_nxt = ffca_pkg::S_DONE;
      end
      ffca_pkg::S_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ffca_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ffca_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ffca_pkg::S_IDLE);
    ram_raddr = idx_r[ffca_pkg::IDX_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = hit_idx_r;
    ram_wdata = hit_ent_r;
    case (state_r)
      ffca_pkg::S_DECIDE: begin
        if (find_r) begin
          if (hit_r) begin
            if (cmd_r == ffca_pkg::CMD_FREE) begin
              ram_we            = 1'b1;
              ram_wdata.is_free = 1'b1;
            end else if (cmd_r == ffca_pkg::CMD_RESIZE) begin
              if (size_r == 16'd0) begin
                ram_we            = 1'b1;
                ram_wdata.is_free = 1'b1;
              end else if (hit_ent_r.cap >= {1'b0, size_r}) begin
                ram_we         = 1'b1;
                ram_wdata.used = size_r;
              end
            end
          end
        end else if (hit_r) begin
          ram_we            = 1'b1;
          ram_wdata.used    = size_r;
          ram_wdata.is_free = 1'b0;
        end else if (fits) begin
          ram_we            = 1'b1;
          ram_waddr         = total_r[ffca_pkg::IDX_W-1:0];
          ram_wdata.start   = data_w[15:0];
          ram_wdata.cap     = cap_new;
          ram_wdata.used    = size_r;
          ram_wdata.is_free = 1'b0;
        end
      end
      ffca_pkg::S_WR_OLD: begin
        ram_we            = 1'b1;
        ram_waddr         = old_idx_r;
        ram_wdata         = old_ent_r;
        ram_wdata.is_free = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffca_pkg::S_IDLE;
      total_r     <= '0;
      heap_end_r  <= ffca_pkg::HEAP_W'(ffca_pkg::HEADER_BYTES);
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      heap_end_r  <= heap_end_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    size_r    <= size_nxt;
    count_r   <= count_nxt;
    addr_r    <= addr_nxt;
    idx_r     <= idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    hit_r     <= hit_nxt;
    hit_idx_r <= hit_idx_nxt;
    hit_ent_r <= hit_ent_nxt;
    old_idx_r <= old_idx_nxt;
    old_ent_r <= old_ent_nxt;
    find_r    <= find_nxt;
    move_r    <= move_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  ffca_ram #(
    .WIDTH(EW),
    .DEPTH(ffca_pkg::MAX_CHUNKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata_raw)
  );

endmodule
